// ===== design/toeq_pkg.sv =====
// toeq_pkg: shared types, command and status codes for the time-ordered event queue
`timescale 1ns / 1ps
package toeq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned PAYLOAD_W       = 16;

  // input command codes
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // per-cell operation broadcast along the row
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // one stored event
  typedef struct packed {
    logic [TIME_W-1:0]    ev_time;
    logic [PAYLOAD_W-1:0] ev_payload;
  } entry_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    op_t    op;
    logic   ordered;
    entry_t word;
  } cell_ctrl_t;

endpackage

// ===== design/toeq_cell.sv =====
// toeq_cell: one queue slot with local compare and shift toward either neighbor
`timescale 1ns / 1ps
module toeq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                clk,
  input  toeq_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    count,
  input  toeq_pkg::entry_t    left,
  input  toeq_pkg::entry_t    right,
  input  logic                claim_in,
  output logic                claim_out,
  output toeq_pkg::entry_t    data
);

  logic occupied;
  logic mark;

  // this slot is the insert point if it is free, or, for an ordered insert, holds a time not below the new one
  assign occupied  = count > CNT_W'(INDEX);
  assign mark      = !occupied ||
                     (ctrl.ordered && !(data.ev_time < ctrl.word.ev_time));
  assign claim_out = claim_in | mark;

  // slots after the insert point take the left word, removal takes the right word
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      toeq_pkg::OP_STORE: begin
        if (claim_in) begin
          data <= left;
        end else if (mark) begin
          data <= ctrl.word;
        end
      end
      toeq_pkg::OP_REMOVE: begin
        data <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/time_ordered_event_queue_top.sv =====
// time_ordered_event_queue_top: bounded time-ordered event queue built as a row of slot cells
//
//  channel  | handshake              | ports
//  ---------+------------------------+----------------------------------------------------
//  command  | start & !busy          | command, event_time, event_payload
//  result   | done, one cycle only   | head_valid, head_time, head_payload, status,
//           |                        | entry_total
//
// for every command the row of cells compares and shifts in parallel,
// and the result shows on done in the cycle after the command is taken.
// a new command can be taken in every cycle; busy is high only during reset.
// reset clears the entry count and the result strobe; slot contents stay as they are.
// the receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module time_ordered_event_queue_top #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command,
  input  logic [toeq_pkg::TIME_W-1:0]    event_time,
  input  logic [toeq_pkg::PAYLOAD_W-1:0] event_payload,
  output logic                           done,
  output logic                           head_valid,
  output logic [toeq_pkg::TIME_W-1:0]    head_time,
  output logic [toeq_pkg::PAYLOAD_W-1:0] head_payload,
  output logic [1:0]                     status,
  output logic [CNT_W-1:0]               entry_total
);

  logic                 accept;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 full;
  logic                 empty;
  toeq_pkg::cell_ctrl_t ctrl;
  toeq_pkg::entry_t     slot [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] claim;
  logic                 head_valid_next;
  logic [1:0]           status_next;

  assign busy   = rst;
  assign accept = start & !rst;
  assign full   = count == CNT_W'(QUEUE_DEPTH);
  assign empty  = count == '0;

  // decode the command into a row operation, next count and result fields
  always_comb begin
    ctrl.op              = toeq_pkg::OP_HOLD;
    ctrl.ordered         = command == toeq_pkg::CMD_INSERT;
    ctrl.word.ev_time    = event_time;
    ctrl.word.ev_payload = event_payload;
    count_next           = count;
    head_valid_next      = 1'b0;
    status_next          = toeq_pkg::ST_OK;
    if (accept) begin
      unique case (toeq_pkg::cmd_t'(command))
        toeq_pkg::CMD_APPEND, toeq_pkg::CMD_INSERT: begin
          if (full) begin
            status_next = toeq_pkg::ST_FULL;
          end else begin
            ctrl.op    = toeq_pkg::OP_STORE;
            count_next = count + 1'b1;
          end
        end
        toeq_pkg::CMD_REMOVE: begin
          if (empty) begin
            status_next = toeq_pkg::ST_EMPTY;
          end else begin
            ctrl.op         = toeq_pkg::OP_REMOVE;
            count_next      = count - 1'b1;
            head_valid_next = 1'b1;
          end
        end
        toeq_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // row of slot cells, head in cell 0
  assign claim[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    toeq_pkg::entry_t left_word;
    toeq_pkg::entry_t right_word;
    if (i == 0) begin : g_first
      assign left_word = ctrl.word;
    end else begin : g_mid_left
      assign left_word = slot[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_word = slot[i];
    end else begin : g_mid_right
      assign right_word = slot[i+1];
    end
    toeq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left      (left_word),
      .right     (right_word),
      .claim_in  (claim[i]),
      .claim_out (claim[i+1]),
      .data      (slot[i])
    );
  end

  // entry count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    head_valid <= head_valid_next;
    status     <= status_next;
    if (head_valid_next) begin
      head_time    <= slot[0].ev_time;
      head_payload <= slot[0].ev_payload;
    end else begin
      head_time    <= '0;
      head_payload <= '0;
    end
  end

  assign entry_total = count;

endmodule

// ===== design/toeq_checker.sv =====
// toeq_checker: port-level checks on the event queue, bound to the top level
`timescale 1ns / 1ps
module toeq_checker #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     command,
  input logic                           done,
  input logic                           head_valid,
  input logic [toeq_pkg::TIME_W-1:0]    head_time,
  input logic [toeq_pkg::PAYLOAD_W-1:0] head_payload,
  input logic [1:0]                     status,
  input logic [CNT_W-1:0]               entry_total
);

  // one result word for each accepted command, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result word after an accepted command");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result word without an accepted command");

  // a removed head comes only from a remove and always with ok status
  a_head_ok: assert property (@(posedge clk) disable iff (rst)
    (done && head_valid) |-> (status == toeq_pkg::ST_OK && $past(command) ==
                              toeq_pkg::CMD_REMOVE))
    else $error("head word with wrong status or command");

  // an empty report leaves the queue empty, a full report leaves it full
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == toeq_pkg::ST_EMPTY) |-> (entry_total == '0 && !head_valid))
    else $error("empty status with stored entries");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == toeq_pkg::ST_FULL) |-> entry_total == CNT_W'(QUEUE_DEPTH))
    else $error("full status with free slots");

endmodule

bind time_ordered_event_queue_top toeq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .CNT_W       (CNT_W)
) u_toeq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .done         (done),
  .head_valid   (head_valid),
  .head_time    (head_time),
  .head_payload (head_payload),
  .status       (status),
  .entry_total  (entry_total)
);

// ===== tb/sv/time_ordered_event_queue_checker.sv =====
// time_ordered_event_queue_checker: tracks the event queue contents and checks every result word
`timescale 1ns / 1ps
module time_ordered_event_queue_checker #(
  parameter int unsigned DEPTH = toeq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     command,
  input  logic [toeq_pkg::TIME_W-1:0]    event_time,
  input  logic [toeq_pkg::PAYLOAD_W-1:0] event_payload,
  input  logic                           done,
  input  logic                           head_valid,
  input  logic [toeq_pkg::TIME_W-1:0]    head_time,
  input  logic [toeq_pkg::PAYLOAD_W-1:0] head_payload,
  input  logic [1:0]                     status,
  input  logic [CNT_W-1:0]               entry_total,
  output int unsigned                    error_count,
  output int unsigned                    pending_count
);
  import toeq_pkg::*;

  typedef struct packed {
    logic                 hv;
    logic [TIME_W-1:0]    ht;
    logic [PAYLOAD_W-1:0] hp;
    logic [1:0]           st;
    logic [CNT_W-1:0]     total;
  } outcome_t;

  // shadow copy of the stored events
  logic [TIME_W-1:0]    queue_times [DEPTH];
  logic [PAYLOAD_W-1:0] queue_payloads [DEPTH];
  int unsigned          queue_fill = 0;

  outcome_t     owed_results[$];
  int unsigned  fail_total = 0;
  int unsigned  owed_depth = 0;
  int unsigned  shown = 0;

  assign error_count   = fail_total;
  assign pending_count = owed_depth;

  // apply one command word to the shadow queue and queue up its result
  task automatic apply_command(input cmd_t c, input logic [TIME_W-1:0] t,
                               input logic [PAYLOAD_W-1:0] p);
    outcome_t    r;
    int unsigned slot;
    r = '0;
    case (c)
      CMD_CLEAR: begin
        queue_fill = 0;
      end
      CMD_REMOVE: begin
        if (queue_fill == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.hv = 1'b1;
          r.ht = queue_times[0];
          r.hp = queue_payloads[0];
          for (int i = 1; i < int'(queue_fill); i++) begin
            queue_times[i-1]    = queue_times[i];
            queue_payloads[i-1] = queue_payloads[i];
          end
          queue_fill--;
        end
      end
      default: begin
        if (queue_fill >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          slot = queue_fill;
          // ordered insert goes ahead of the first entry not earlier than t
          if (c == CMD_INSERT) begin
            for (int i = int'(queue_fill) - 1; i >= 0; i--) begin
              if (!(queue_times[i] < t)) slot = i;
            end
          end
          for (int i = int'(queue_fill); i > int'(slot); i--) begin
            queue_times[i]    = queue_times[i-1];
            queue_payloads[i] = queue_payloads[i-1];
          end
          queue_times[slot]    = t;
          queue_payloads[slot] = p;
          queue_fill++;
        end
      end
    endcase
    r.total = queue_fill[CNT_W-1:0];
    owed_results.push_back(r);
  endtask

  task automatic check_field(input string label, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      fail_total++;
      if (shown < 10) begin
        shown++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, label, want, got);
      end
    end
  endtask

  // compare result words first, then take in the command word of this edge
  always @(posedge clk) begin
    outcome_t owed;
    if (rst) begin
      queue_fill = 0;
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          fail_total++;
          if (shown < 10) begin
            shown++;
            $display("%0t: unexpected result word, status %0d, count %0d", $realtime,
                     status, entry_total);
          end
        end else begin
          owed = owed_results.pop_front();
          check_field("head_valid", TIME_W'(owed.hv), TIME_W'(head_valid));
          check_field("head_time", owed.ht, head_time);
          check_field("head_payload", TIME_W'(owed.hp), TIME_W'(head_payload));
          check_field("status", TIME_W'(owed.st), TIME_W'(status));
          check_field("entry_total", TIME_W'(owed.total), TIME_W'(entry_total));
        end
      end
      if (start && !busy) apply_command(cmd_t'(command), event_time, event_payload);
    end
    owed_depth = owed_results.size();
  end

endmodule

// ===== tb/sv/time_ordered_event_queue_top_test.sv =====
// time_ordered_event_queue_top_test: command stimulus and verdict for the event queue
`timescale 1ns / 1ps
module time_ordered_event_queue_top_test;
  import toeq_pkg::*;

  localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           command;
  logic [TIME_W-1:0]    event_time;
  logic [PAYLOAD_W-1:0] event_payload;
  logic                 done;
  logic                 head_valid;
  logic [TIME_W-1:0]    head_time;
  logic [PAYLOAD_W-1:0] head_payload;
  logic [1:0]           status;
  logic [CNT_W-1:0]     entry_total;
  int unsigned          error_count;
  int unsigned          pending_count;
  bit                   idle_on = 1'b1;

  always #10 clk = ~clk;

  time_ordered_event_queue_top #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .event_time(event_time), .event_payload(event_payload), .done(done),
    .head_valid(head_valid), .head_time(head_time), .head_payload(head_payload),
    .status(status), .entry_total(entry_total)
  );

  time_ordered_event_queue_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .event_time(event_time), .event_payload(event_payload), .done(done),
    .head_valid(head_valid), .head_time(head_time), .head_payload(head_payload),
    .status(status), .entry_total(entry_total), .error_count(error_count),
    .pending_count(pending_count)
  );

  // one command word: optional idle gap, then hold until taken
  task automatic send_word(input cmd_t c, input logic [TIME_W-1:0] t,
                           input logic [PAYLOAD_W-1:0] p);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start         <= 1'b1;
    command       <= c;
    event_time    <= t;
    event_payload <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // event times: narrow range for ties, extremes, or anything
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return TIME_W'($urandom_range(0, 15));
    if (roll < 50) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return 32'd1;
        2:       return '1;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  // stimulus
  initial begin
    cmd_t                 c;
    logic [PAYLOAD_W-1:0] p;
    int unsigned          mode;
    int unsigned          roll;
    int unsigned          store_pct;
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_APPEND;
    event_time    = '0;
    event_payload = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue, extremes, ties, front and back inserts
    send_word(CMD_REMOVE, '1, '1);
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_INSERT, 32'd100, 16'h0001);
    send_word(CMD_INSERT, 32'd100, 16'h0002);
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_APPEND, 32'd50, 16'hA5A5);
    send_word(CMD_APPEND, '0, 16'h5A5A);
    // fill to the brim, then push into a full queue
    for (int i = 0; i < 10; i++) send_word(CMD_INSERT, pick_time(), PAYLOAD_W'($urandom));
    send_word(CMD_APPEND, 32'd7, 16'h1234);
    send_word(CMD_INSERT, '0, 16'h4321);
    send_word(CMD_REMOVE, '0, '0);
    send_word(CMD_REMOVE, '0, '0);
    send_word(CMD_CLEAR, '1, '1);
    send_word(CMD_REMOVE, '0, '0);

    // random: phases that lean toward filling, draining or balance
    mode = 0;
    for (int n = 0; n < 1150; n++) begin
      idle_on = !(n >= 450 && n < 650);
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      store_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 52;
      roll = $urandom_range(0, 99);
      if (roll < 2) c = CMD_CLEAR;
      else if (roll < 2 + store_pct) c = ($urandom_range(0, 99) < 65) ? CMD_INSERT : CMD_APPEND;
      else c = CMD_REMOVE;
      p = PAYLOAD_W'($urandom);
      if ($urandom_range(0, 99) < 5) p = $urandom_range(0, 1) ? '1 : '0;
      send_word(c, pick_time(), p);
    end
    start <= 1'b0;

    // drain and give the verdict
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("time_ordered_event_queue_top_test: done, clean");
    end else begin
      $display("time_ordered_event_queue_top_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("time_ordered_event_queue_top_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/toeq_pkg.sv
design/toeq_cell.sv
design/time_ordered_event_queue_top.sv
design/toeq_checker.sv
tb/sv/time_ordered_event_queue_checker.sv
tb/sv/time_ordered_event_queue_top_test.sv
